>>> design/i2da_pkg.sv
// Package for the integer to decimal ASCII unit.
// Holds shared constants, the converter control struct and the digit count function.
// No dependencies.
package i2da_pkg;

    // Default width of the signed input value
    localparam int VALUE_BITS_DEF = 32;

    // Output character width
    localparam int CHAR_BITS = 6;

    // ASCII codes, sized to the character width
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 6'd57;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

    // Double-dabble correction: digits of five or more get three added before a shift
    localparam logic [3:0] BCD_FIX_MIN = 4'd5;
    localparam logic [3:0] BCD_FIX_ADD = 4'd3;

    // Control from the sequencer to the converter
    typedef struct packed {
        logic load;   // take a new magnitude, clear the BCD register
        logic step;   // one double-dabble bit step
        logic shift;  // move the BCD register up by one digit
    } i2da_ctrl_t;

    // Upper bound on decimal digits of a magnitude of up to bits bits
    // (1233 / 4096 approximates log10(2) from below)
    function automatic int bcd_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

>>> design/i2da_in_if.sv
// Input channel of the integer to decimal ASCII unit: valid/ready plus the value.
// Depends on i2da_pkg.
interface i2da_in_if
    import i2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> design/i2da_out_if.sv
// Output channel of the integer to decimal ASCII unit: valid/ready plus one character.
// Depends on i2da_pkg.
interface i2da_out_if
    import i2da_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] ascii_char;
    logic                 last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

>>> design/i2da_conv.sv
// Bit-serial binary to BCD converter (shift and add-3) with a digit shift-out path.
// Depends on i2da_pkg.
module i2da_conv
    import i2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  i2da_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] mag,
    output logic [3:0]            top_digit
);

    localparam int DIGITS   = bcd_digits(VALUE_BITS);
    localparam int BCD_BITS = 4 * DIGITS;

    logic [VALUE_BITS-1:0] mag_reg,  mag_next;
    logic [BCD_BITS-1:0]   bcd_reg,  bcd_next;
    logic [BCD_BITS-1:0]   bcd_fix;

    // Add-3 correction on every digit, all independent
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= BCD_FIX_MIN)
                bcd_fix[4*i +: 4] = bcd_reg[4*i +: 4] + BCD_FIX_ADD;
            else
                bcd_fix[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Next state of the magnitude and BCD shift registers
    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            mag_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_fix[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
        end
        else if (ctrl.shift)
        begin
            bcd_next = {bcd_reg[BCD_BITS-5:0], 4'b0000};
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

endmodule

>>> design/integer_to_decimal_ascii_unit.sv
// Top level of the integer to decimal ASCII unit: sequencer and output register.
// Depends on i2da_pkg, i2da_in_if, i2da_out_if and i2da_conv.
//
//  channel  dir  payload                         transaction
//  din      in   value (VALUE_BITS, signed)      one integer to format
//  dout     out  ascii_char (6), last (1)        one character of the text
//
// One integer is accepted, then converted in VALUE_BITS shift-and-add-3 steps; the
// minus sign follows when negative, then one BCD digit position per cycle while dout
// is not stalled (bcd_digits(VALUE_BITS), 10 at 32 bits), leading zeros skipped.
// din is ready only between integers.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the output valid.
// A stalled dout holds its character and pauses the digit emission.
module integer_to_decimal_ascii_unit
    import i2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    i2da_in_if.sink     din,
    i2da_out_if.source  dout
);

    localparam int DIGITS    = bcd_digits(VALUE_BITS);
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg,   state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic                 neg_reg,     neg_next;
    logic                 started_reg, started_next;
    logic                 ovalid_reg,  ovalid_next;
    logic [CHAR_BITS-1:0] char_reg,    char_next;
    logic                 last_reg,    last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  raw_neg;
    logic [3:0]            top_digit;
    logic                  accept;
    logic                  can_load;
    logic                  digit_final;
    logic                  skip;
    logic                  emit;
    logic                  sign_load;
    i2da_ctrl_t            ctrl;

    // Magnitude of the incoming value; the most negative value maps to 2^(VALUE_BITS-1)
    assign raw     = din.value;
    assign raw_neg = raw[VALUE_BITS-1];
    assign mag     = raw_neg ? VALUE_BITS'(~raw + 1'b1) : raw;

    // Handshake and emission decisions
    assign din.ready   = (state_reg == ST_IDLE);
    assign accept      = din.valid && din.ready;
    assign can_load    = !ovalid_reg || dout.ready;
    assign digit_final = (dig_cnt_reg == '0);
    assign skip        = (state_reg == ST_EMIT) && (top_digit == 4'd0)
                         && !started_reg && !digit_final;
    assign emit        = (state_reg == ST_EMIT) && !skip && can_load;
    assign sign_load   = (state_reg == ST_SIGN) && can_load;

    assign ctrl.load  = accept;
    assign ctrl.step  = (state_reg == ST_CONV);
    assign ctrl.shift = skip || emit;

    i2da_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .clk       (clk),
        .ctrl      (ctrl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = raw_neg;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (sign_load)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (skip || emit)
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                if (emit)
                begin
                    started_next = 1'b1;
                    if (digit_final)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (sign_load)
        begin
            ovalid_next = 1'b1;
            char_next   = ASCII_MINUS;
            last_next   = 1'b0;
        end
        else if (emit)
        begin
            ovalid_next = 1'b1;
            char_next   = ASCII_ZERO + {2'b00, top_digit};
            last_next   = digit_final;
        end
        else if (dout.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
        end
    end

    // Payload and counter registers, no reset
    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign dout.valid      = ovalid_reg;
    assign dout.ascii_char = char_reg;
    assign dout.last       = last_reg;

endmodule

>>> design/i2da_checker.sv
// Port-level checker for the integer to decimal ASCII unit, with its bind statement.
// Depends on i2da_pkg and integer_to_decimal_ascii_unit.
module i2da_checker
    import i2da_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 din_valid,
    input logic                 din_ready,
    input logic                 dout_valid,
    input logic                 dout_ready,
    input logic [CHAR_BITS-1:0] ascii_char,
    input logic                 last
);

    logic run_start_reg;

    // Tracks whether the next output character opens a new run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_start_reg <= 1'b1;
        else if (dout_valid && dout_ready)
            run_start_reg <= last;
    end

    // A stalled character holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(ascii_char) && $stable(last))
        else $error("stalled output character changed");

    // Only the minus sign or a digit leaves the block
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> (ascii_char == ASCII_MINUS)
                       || (ascii_char >= ASCII_ZERO && ascii_char <= ASCII_NINE))
        else $error("illegal output character");

    // A minus sign opens a run and never ends one
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && ascii_char == ASCII_MINUS |-> run_start_reg && !last)
        else $error("misplaced minus sign");

    // A leading zero is only ever the whole text of zero
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && run_start_reg && ascii_char == ASCII_ZERO |-> last)
        else $error("leading zero emitted");

    // One integer at a time: after a transaction on din, din is not ready
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready |=> !din_ready)
        else $error("input taken while converting");

endmodule

bind integer_to_decimal_ascii_unit i2da_checker u_i2da_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_valid  (din.valid),
    .din_ready  (din.ready),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .ascii_char (dout.ascii_char),
    .last       (dout.last)
);

>>> tb/sv/i2da_text_checker.sv
// Checker for the integer to decimal ASCII unit: watches both channels,
// predicts the decimal text of each accepted integer and compares every character.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_text_checker
    import i2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  din_valid,
    input  logic                  din_ready,
    input  logic [VALUE_BITS-1:0] din_value,
    input  logic                  dout_valid,
    input  logic                  dout_ready,
    input  logic [CHAR_BITS-1:0]  dout_char,
    input  logic                  dout_last,
    output int                    error_count,
    output int                    pending
);

    // Longest digit run of a 64-bit magnitude
    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } text_char_t;

    text_char_t expected_text[$];

    // Decimal text of one integer, pushed in emission order
    function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
        logic                  negative;
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits [MAX_DIGITS];
        int                    count;
        text_char_t            c;
        negative = raw[VALUE_BITS-1];
        // unsigned magnitude, so the most negative value converts cleanly
        mag      = negative ? (~raw + 1'b1) : raw;
        count    = 0;
        if (mag == '0)
        begin
            c.ch   = ASCII_ZERO;
            c.last = 1'b1;
            expected_text.push_back(c);
            return;
        end
        while (mag != '0)
        begin
            digits[count] = 4'(mag % 10);
            mag           = mag / 10;
            count++;
        end
        if (negative)
        begin
            c.ch   = ASCII_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            c.ch   = ASCII_ZERO + {2'b00, digits[i]};
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Compare output transactions first, then queue the text of a new integer
    always @(posedge clk)
    begin
        text_char_t exp_char;
        int         errs;
        errs = 0;
        if (!rst_n)
        begin
            error_count <= 0;
            pending     <= 0;
        end
        else
        begin
            if (dout_valid && dout_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                             $time, dout_char, dout_last);
                    errs = errs + 1;
                end
                else
                begin
                    exp_char = expected_text.pop_front();
                    if (dout_char !== exp_char.ch)
                    begin
                        $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                                 $time, exp_char.ch, dout_char);
                        errs = errs + 1;
                    end
                    if (dout_last !== exp_char.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, exp_char.last, dout_last);
                        errs = errs + 1;
                    end
                end
            end
            if (din_valid && din_ready)
                predict_text(din_value);
            error_count <= error_count + errs;
            pending     <= expected_text.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the integer to decimal ASCII unit testbench: clock, reset, stimulus and verdict.
// Depends on i2da_pkg, i2da_in_if, i2da_out_if, the unit and i2da_text_checker.
`timescale 1ns / 1ps

module testbench
    import i2da_pkg::*;
();

    localparam int VALUE_BITS     = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS   = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 60;

    logic clk;
    logic rst_n;
    logic steady;       // no idling on either side while set
    int   idle_cycles;
    int   error_count;
    int   pending;

    i2da_in_if #(.VALUE_BITS(VALUE_BITS)) din_if ();
    i2da_out_if                           dout_if ();

    integer_to_decimal_ascii_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    i2da_text_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .din_valid   (din_if.valid),
        .din_ready   (din_if.ready),
        .din_value   (din_if.value),
        .dout_valid  (dout_if.valid),
        .dout_ready  (dout_if.ready),
        .dout_char   (dout_if.ascii_char),
        .dout_last   (dout_if.last),
        .error_count (error_count),
        .pending     (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: stall with a probability of about 8 percent outside the steady stretch
    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            dout_if.ready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One input transaction, with a random gap in front of it
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= v;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int                    directed_values [];
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] pow10;
        int                    kind;
        int                    exponent;

        directed_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -2,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                            1000000000, -1000000000, 999999999, -999999999,
                            123456789, 32'h5555_5555, 32'hAAAA_AAAA,
                            1000, -100000};

        steady        = 1'b0;
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero, sign and digit-count boundaries
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Random values: full range, small, around powers of ten, near the extremes
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 40) && (n < 70);
            kind   = $urandom_range(0, 3);
            case (kind)
                0: v = $urandom;
                1: v = $urandom_range(0, 99999);
                2:
                begin
                    exponent = $urandom_range(0, 9);
                    pow10    = 1;
                    for (int e = 0; e < exponent; e++)
                        pow10 = pow10 * 10;
                    v = pow10 + $urandom_range(0, 2) - 1;
                end
                default: v = 32'h7FFF_FFFF - $urandom_range(0, 1000);
            endcase
            if (kind != 0 && $urandom_range(0, 1))
                v = -v;
            send_value(v);
        end
        steady = 1'b0;
        din_if.valid <= 1'b0;

        // Drain the remaining characters
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> integer_to_decimal_ascii_unit.f
design/i2da_pkg.sv
design/i2da_in_if.sv
design/i2da_out_if.sv
design/i2da_conv.sv
design/integer_to_decimal_ascii_unit.sv
design/i2da_checker.sv
tb/sv/i2da_text_checker.sv
tb/sv/testbench.sv
